FILE: rtl/assert_macros.svh
// Assertion macros used by the checker module mbaf_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define MBAF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion violated");

// Clocked assertion that is also checked during reset.
`define MBAF_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion violated during or after reset");

`endif

FILE: rtl/mbaf_pkg.sv
package mbaf_pkg;

    localparam logic [6:0] CH_START = 7'h3A;
    localparam logic [6:0] CH_CR    = 7'h0D;
    localparam logic [6:0] CH_LF    = 7'h0A;
    localparam logic [6:0] CH_DIGIT = 7'h30;
    localparam logic [6:0] CH_ALPHA = 7'h37;

    // One classified input item, as handed from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] lrc;
        logic       first;
        logic       last;
    } mbaf_cmd_t;

    // Which character of the current item the back emits next.
    typedef enum logic [2:0] {
        PH_BEGIN,
        PH_START,
        PH_HI,
        PH_LO,
        PH_LRC_HI,
        PH_LRC_LO,
        PH_CR,
        PH_LF
    } mbaf_phase_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] ext;
        ext = {3'b000, nib};
        if (nib <= 4'd9) begin
            return CH_DIGIT + ext;
        end
        return CH_ALPHA + ext;
    endfunction

endpackage

FILE: rtl/mbaf_front.sv
module mbaf_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tlast,
    input  logic               queue_full,
    output logic               push,
    output mbaf_pkg::mbaf_cmd_t cmd
);

    logic [7:0] sum_reg, sum_next;
    logic       in_frame_reg, in_frame_next;
    logic [7:0] sum_new;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;
    assign sum_new  = sum_reg + s_tdata;

    always_comb begin
        cmd.data  = s_tdata;
        cmd.lrc   = (~sum_new) + 8'd1;
        cmd.first = !in_frame_reg;
        cmd.last  = s_tlast;
    end

    always_comb begin
        sum_next      = sum_reg;
        in_frame_next = in_frame_reg;
        if (push) begin
            if (s_tlast) begin
                sum_next      = 8'd0;
                in_frame_next = 1'b0;
            end else begin
                sum_next      = sum_new;
                in_frame_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg      <= 8'd0;
            in_frame_reg <= 1'b0;
        end else begin
            sum_reg      <= sum_next;
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

FILE: rtl/mbaf_fifo.sv
module mbaf_fifo #(
    parameter int DEPTH = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  mbaf_pkg::mbaf_cmd_t push_cmd,
    input  logic               pop,
    output mbaf_pkg::mbaf_cmd_t head_cmd,
    output logic               head_valid,
    output logic               full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mbaf_pkg::mbaf_cmd_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/mbaf_back.sv
module mbaf_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  mbaf_pkg::mbaf_cmd_t head_cmd,
    input  logic               head_valid,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast
);

    mbaf_pkg::mbaf_phase_t phase_reg, phase_next, cur;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [6:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       load;

    assign load = head_valid && (!m_tvalid_reg || m_tready);

    // At the start of an item the first phase depends on whether it opens a frame.
    always_comb begin
        if (phase_reg == mbaf_pkg::PH_BEGIN) begin
            cur = head_cmd.first ? mbaf_pkg::PH_START : mbaf_pkg::PH_HI;
        end else begin
            cur = phase_reg;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        if (load) begin
            case (cur)
                mbaf_pkg::PH_START:  phase_next = mbaf_pkg::PH_HI;
                mbaf_pkg::PH_HI:     phase_next = mbaf_pkg::PH_LO;
                mbaf_pkg::PH_LO: begin
                    phase_next = head_cmd.last ? mbaf_pkg::PH_LRC_HI : mbaf_pkg::PH_BEGIN;
                end
                mbaf_pkg::PH_LRC_HI: phase_next = mbaf_pkg::PH_LRC_LO;
                mbaf_pkg::PH_LRC_LO: phase_next = mbaf_pkg::PH_CR;
                mbaf_pkg::PH_CR:     phase_next = mbaf_pkg::PH_LF;
                mbaf_pkg::PH_LF:     phase_next = mbaf_pkg::PH_BEGIN;
                default:             phase_next = mbaf_pkg::PH_BEGIN;
            endcase
        end
    end

    always_comb begin
        char_next = char_reg;
        last_next = last_reg;
        pop       = 1'b0;
        if (load) begin
            last_next = 1'b0;
            case (cur)
                mbaf_pkg::PH_START:  char_next = mbaf_pkg::CH_START;
                mbaf_pkg::PH_HI:     char_next = mbaf_pkg::hex_char(head_cmd.data[7:4]);
                mbaf_pkg::PH_LO: begin
                    char_next = mbaf_pkg::hex_char(head_cmd.data[3:0]);
                    pop       = !head_cmd.last;
                end
                mbaf_pkg::PH_LRC_HI: char_next = mbaf_pkg::hex_char(head_cmd.lrc[7:4]);
                mbaf_pkg::PH_LRC_LO: char_next = mbaf_pkg::hex_char(head_cmd.lrc[3:0]);
                mbaf_pkg::PH_CR:     char_next = mbaf_pkg::CH_CR;
                mbaf_pkg::PH_LF: begin
                    char_next = mbaf_pkg::CH_LF;
                    last_next = 1'b1;
                    pop       = 1'b1;
                end
                default:             char_next = mbaf_pkg::CH_START;
            endcase
        end
    end

    always_comb begin
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= mbaf_pkg::PH_BEGIN;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;

endmodule

FILE: rtl/modbus_ascii_frame_encoder.sv
// Channel   Dir  tdata (low bit up)        tlast      tuser
// s_        in   pdu_byte[7:0]             last_in    -
// m_        out  ascii_char[6:0], 0 pad    last_out   -
//
// One output character per cycle while m_tready is high and a byte is queued; a middle
// byte makes 2 chars, an opener 3, a closer 6, a lone byte 7; one sequencer sets this.
// Input bytes are queued (QUEUE_DEPTH items) so the front accepts while the back works.
// Synchronous active-low reset clears sum, frame flag, queue and output valid.
// A stall on m_ holds the output register; s_tready falls only when the queue is full.
module modbus_ascii_frame_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] pdu_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] ascii_char, [7] zero
    output logic       m_tlast
);

    mbaf_pkg::mbaf_cmd_t push_cmd, head_cmd;
    logic push, pop, head_valid, queue_full;

    mbaf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    mbaf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .full       (queue_full)
    );

    mbaf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: rtl/mbaf_checker.sv
`include "assert_macros.svh"

module mbaf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A stalled output item keeps its character and its last flag.
    `MBAF_ASSERT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // The frame always closes on a line feed.
    `MBAF_ASSERT(a_last_is_lf, aclk, aresetn, m_tvalid && m_tlast |-> m_tdata == {1'b0, mbaf_pkg::CH_LF})

    // Characters are 7-bit ASCII.
    `MBAF_ASSERT(a_ascii_range, aclk, aresetn, m_tvalid |-> !m_tdata[7])

    // Reset drops the output valid by the following edge.
    `MBAF_ASSERT_RST(a_reset_clears, aclk, !aresetn |=> !m_tvalid)

endmodule

bind modbus_ascii_frame_encoder mbaf_checker u_mbaf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: dv/modbus_ascii_frame_checker.sv
module modbus_ascii_frame_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    output int         fail_count,
    output int         pending_chars
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } line_char_t;

    line_char_t  expected_chars[$];
    logic [7:0]  frame_sum;
    logic        frame_open;
    int          mismatches;

    initial begin
        fail_count    = 0;
        pending_chars = 0;
        mismatches    = 0;
        frame_sum     = '0;
        frame_open    = 1'b0;
    end

    function automatic logic [6:0] hex_digit(input logic [3:0] nib);
        if (nib <= 4'd9) begin
            return mbaf_pkg::CH_DIGIT + 7'(nib);
        end
        return mbaf_pkg::CH_ALPHA + 7'(nib);
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("[%0t] mismatch on %s: expected 0x%02h, got 0x%02h", $realtime, what,
                 want, got);
        mismatches++;
    endtask

    // Appends the characters that one body byte produces on the serial line.
    task automatic encode_byte(input logic [7:0] b, input logic is_last);
        logic [7:0] lrc;
        if (!frame_open) begin
            expected_chars.push_back('{mbaf_pkg::CH_START, 1'b0});
            frame_open = 1'b1;
        end
        expected_chars.push_back('{hex_digit(b[7:4]), 1'b0});
        expected_chars.push_back('{hex_digit(b[3:0]), 1'b0});
        frame_sum = frame_sum + b;
        if (is_last) begin
            lrc = ~frame_sum + 8'd1;
            expected_chars.push_back('{hex_digit(lrc[7:4]), 1'b0});
            expected_chars.push_back('{hex_digit(lrc[3:0]), 1'b0});
            expected_chars.push_back('{mbaf_pkg::CH_CR, 1'b0});
            expected_chars.push_back('{mbaf_pkg::CH_LF, 1'b1});
            frame_sum  = '0;
            frame_open = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        line_char_t want;
        if (!aresetn) begin
            expected_chars.delete();
            frame_sum  = '0;
            frame_open = 1'b0;
        end else begin
            // Results are checked before the new item is queued, since an item
            // cannot leave the block at the edge that accepts it.
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("unexpected item", 8'h00, m_tdata);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata[6:0] !== want.ch) begin
                        report_mismatch("ascii_char", {1'b0, want.ch}, {1'b0, m_tdata[6:0]});
                    end
                    if (m_tdata[7] !== 1'b0) begin
                        report_mismatch("tdata pad bit", 8'h00, {7'b0, m_tdata[7]});
                    end
                    if (m_tlast !== want.last) begin
                        report_mismatch("last_out", {7'b0, want.last}, {7'b0, m_tlast});
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                encode_byte(s_tdata, s_tlast);
            end
        end
        pending_chars <= expected_chars.size();
        fail_count    <= mismatches;
    end

endmodule

FILE: dv/tb_modbus_ascii_frame_encoder.sv
module tb_modbus_ascii_frame_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 138;
    localparam int QUIET_AFTER  = 110;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int fail_count;
    int pending_chars;
    int cycle_count;
    bit quiet;
    int stall_left;

    modbus_ascii_frame_encoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    modbus_ascii_frame_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_chars (pending_chars)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The receiver stalls in short bursts until the quiet stretch at the end.
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0) begin
                    stall_left = $urandom_range(1, 3);
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task automatic send_frame(input logic [7:0] body[$]);
        foreach (body[i]) begin
            send_byte(body[i], i == body.size() - 1);
        end
    endtask

    // Holds the input side idle until every queued character has come out.
    task automatic drain_output();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_chars != 0);
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] corners[4] = '{8'h00, 8'hFF, 8'h0F, 8'hF0};
        if ($urandom_range(0, 7) == 0) begin
            return corners[$urandom_range(0, 3)];
        end
        return 8'($urandom);
    endfunction

    initial begin
        int sent;
        int frame_len;
        bit drained_mid;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        quiet       = 1'b0;
        drained_mid = 1'b0;
        aresetn     = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // One-byte frames at the extremes, a read request, a zero-sum frame,
        // a frame that walks every nibble value and a closing one-byte 7F frame.
        send_frame('{8'h00});
        send_frame('{8'hFF});
        send_frame('{8'h01, 8'h03, 8'h00, 8'h6B, 8'h00, 8'h03});
        send_frame('{8'h80, 8'h80});
        send_frame('{8'h0F, 8'hF0, 8'h5A, 8'hA5, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC,
                     8'hDE});
        send_frame('{8'h7F});
        drain_output();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       frame_len = $urandom_range(17, 40);
                1, 2:    frame_len = $urandom_range(9, 16);
                default: frame_len = $urandom_range(1, 8);
            endcase
            // The last frame is cut short so the item count stays on target.
            if (frame_len > RANDOM_ITEMS - sent) begin
                frame_len = RANDOM_ITEMS - sent;
            end
            for (int i = 0; i < frame_len; i++) begin
                send_byte(pick_byte(), i == frame_len - 1);
                sent++;
                if (sent >= QUIET_AFTER) begin
                    quiet = 1'b1;
                end
                // A drain in the middle of a frame leaves the block waiting for the rest.
                if (!drained_mid && sent >= 60 && i < frame_len - 1) begin
                    drain_output();
                    drained_mid = 1'b1;
                end
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_chars != 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
